### rtl/core/ibusfd_pkg.sv
// ibus frame decoder: shared types and constants
// used by ibusfd_csum and ibus_frame_decoder, depends on nothing
package ibusfd_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN     = 32;
    localparam int unsigned CSUM_BYTES    = 30;
    localparam int unsigned BASE_CHANNELS = 14;
    localparam int unsigned CHANNEL_MAX   = 18;

    localparam logic [7:0]  HDR_LEN_BYTE  = 8'h20;
    localparam logic [7:0]  HDR_CMD_BYTE  = 8'h40;
    localparam logic [15:0] CSUM_INIT     = 16'hFFFF;
    localparam logic [7:0]  NIB_LO_MASK   = 8'h0F;
    localparam logic [7:0]  NIB_HI_MASK   = 8'hF0;

    // configuration register indexes
    localparam logic [1:0]  REG_DECODER_ENABLE  = 2'd0;
    localparam logic [1:0]  REG_EXTENDED_ENABLE = 2'd1;

    // control of the checksum accumulator
    typedef struct packed {
        logic clr;  // load the initial value
        logic sub;  // subtract the operand
        logic hi;   // operand is the byte shifted into the upper half
    } csum_ctrl_t;

endpackage

### rtl/core/ibusfd_csum.sv
// ibus frame decoder: 16-bit wrapping checksum accumulator
// one shared subtractor stepped by the top-level sequencer; uses ibusfd_pkg
module ibusfd_csum (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ibusfd_pkg::csum_ctrl_t  ctrl,
    input  logic [7:0]              byte_in,
    output logic                    zero
);

    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic [15:0] operand;

    // the received checksum is subtracted too: a good frame ends at zero
    assign operand = ctrl.hi ? {byte_in, 8'h00} : {8'h00, byte_in};

    always_comb
    begin
        priority if (ctrl.clr)
        begin
            acc_next = ibusfd_pkg::CSUM_INIT;
        end
        else if (ctrl.sub)
        begin
            acc_next = acc_reg - operand;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    // accumulator register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= ibusfd_pkg::CSUM_INIT;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign zero = (acc_reg == 16'h0000);

    // a clear always leaves the initial value behind
    a_clr_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clr |=> acc_reg == ibusfd_pkg::CSUM_INIT)
        else $error("checksum accumulator not cleared");

    // without a command the accumulator holds
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctrl.clr && !ctrl.sub) |=> $stable(acc_reg))
        else $error("checksum accumulator moved while idle");

    // clear and subtract are never asked for together
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.clr && ctrl.sub))
        else $error("checksum clear and subtract at once");

endmodule

### rtl/core/ibus_frame_decoder.sv
// ibus frame decoder top level: byte collection, frame memory, sequencer
// depends on ibusfd_pkg and ibusfd_csum
//
//  channel   direction  signals                      payload
//  s_*       in         s_tvalid s_tready s_tdata    rx_byte [7:0]
//  m_*       out        m_tvalid m_tready m_tdata    channel_index, channel_value
//                       m_tlast                      last_channel
//  cfg_*     in         cfg_wr_en cfg_addr cfg_wdata decoder_enable, extended_enable
//
// received bytes are taken while s_tready is high; the byte that completes a frame
// starts a checksum pass over the frame memory (one read port, one byte a cycle)
// and a verdict, then a fetch and an emit for each channel (base channels read two
// bytes, extra channels three); the emit waits while the result is stalled.
// s_tready is low from that pass until the last channel or a bad checksum. reset clears position,
// state and registers; frame memory is not cleared, every byte is written before use.
module ibus_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [4:0] channel_index, [16:5] channel_value, rest zero
    output logic        m_tlast,    // last_channel
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic        cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHK,
        ST_FETCH,
        ST_EMIT
    } state_t;

    localparam logic [4:0] LAST_BASE = 5'(ibusfd_pkg::BASE_CHANNELS - 1);
    localparam logic [4:0] LAST_EXT  = 5'(ibusfd_pkg::CHANNEL_MAX - 1);
    localparam logic [4:0] POS_LAST  = 5'(ibusfd_pkg::FRAME_LEN - 1);
    localparam logic [5:0] SUM_END   = 6'(ibusfd_pkg::FRAME_LEN);
    localparam logic [5:0] SUM_CUT   = 6'(ibusfd_pkg::CSUM_BYTES);

    // configuration registers
    logic dec_en_reg;
    logic ext_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_en_reg <= 1'b0;
            ext_en_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_addr == ibusfd_pkg::REG_DECODER_ENABLE)
            begin
                dec_en_reg <= cfg_wdata;
            end
            if (cfg_addr == ibusfd_pkg::REG_EXTENDED_ENABLE)
            begin
                ext_en_reg <= cfg_wdata;
            end
        end
    end

    state_t      state_reg, state_next;
    logic [4:0]  pos_reg, pos_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [4:0]  ch_reg, ch_next;
    logic [1:0]  stp_reg, stp_next;
    logic [11:0] val_reg, val_next;
    logic        ext_reg, ext_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [4:0]  out_idx_reg, out_idx_next;
    logic [11:0] out_val_reg, out_val_next;
    logic        out_last_reg, out_last_next;

    logic        in_xfer;
    logic        mem_we;
    logic [4:0]  rd_addr;
    logic [7:0]  rd_data_reg;
    logic [7:0]  frame_mem [ibusfd_pkg::FRAME_LEN];

    ibusfd_pkg::csum_ctrl_t csum_ctrl;
    logic        csum_zero;

    // fetch addressing
    logic        is_ext;
    logic [4:0]  ext_ch;
    logic [1:0]  ext_m;
    logic [1:0]  fetch_n;
    logic [1:0]  fetch_j;
    logic [4:0]  fetch_addr;
    logic [4:0]  last_ch;
    logic        out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign is_ext  = (ch_reg >= 5'(ibusfd_pkg::BASE_CHANNELS));
    assign ext_ch  = ch_reg - 5'(ibusfd_pkg::BASE_CHANNELS);
    assign ext_m   = ext_ch[1:0];
    assign fetch_n = is_ext ? 2'd3 : 2'd2;
    assign fetch_j = stp_reg - 2'd1;
    assign last_ch = ext_reg ? LAST_EXT : LAST_BASE;

    // base channel k reads 2+2k then 3+2k; extra channel m reads 3+6m, +2, +4
    always_comb
    begin
        if (is_ext)
        begin
            fetch_addr = 5'd3 + {1'b0, ext_m, 2'b00} + {2'b00, ext_m, 1'b0}
                         + {2'b00, stp_reg, 1'b0};
        end
        else
        begin
            fetch_addr = 5'd2 + {ch_reg[3:0], 1'b0} + {4'b0000, stp_reg[0]};
        end
    end

    assign rd_addr = (state_reg == ST_SUM) ? cnt_reg[4:0] : fetch_addr;
    assign mem_we  = in_xfer && dec_en_reg
                     && (pos_reg != 5'd0 || s_tdata == ibusfd_pkg::HDR_LEN_BYTE)
                     && (pos_reg != 5'd1 || s_tdata == ibusfd_pkg::HDR_CMD_BYTE);

    // frame memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[pos_reg] <= s_tdata;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    ibusfd_csum u_csum (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (csum_ctrl),
        .byte_in (rd_data_reg),
        .zero    (csum_zero)
    );

    // sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        ch_next       = ch_reg;
        stp_next      = stp_reg;
        val_next      = val_reg;
        ext_next      = ext_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_idx_next  = out_idx_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        csum_ctrl     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && dec_en_reg)
                begin
                    if (pos_reg == 5'd1 && s_tdata != ibusfd_pkg::HDR_CMD_BYTE)
                    begin
                        // bad command byte: restart the hunt, byte dropped
                        pos_next = 5'd0;
                    end
                    else if (mem_we)
                    begin
                        if (pos_reg == POS_LAST)
                        begin
                            pos_next      = 5'd0;
                            cnt_next      = 6'd0;
                            ext_next      = ext_en_reg;
                            csum_ctrl.clr = 1'b1;
                            state_next    = ST_SUM;
                        end
                        else
                        begin
                            pos_next = pos_reg + 5'd1;
                        end
                    end
                end
            end

            ST_SUM:
            begin
                // data for byte cnt-1 arrives; last two bytes are the checksum word
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg != 6'd0 && (cnt_reg <= SUM_CUT || cnt_reg >= SUM_CUT + 6'd2))
                begin
                    csum_ctrl.sub = 1'b1;
                end
                else if (cnt_reg == SUM_CUT + 6'd1)
                begin
                    csum_ctrl.sub = 1'b1;
                end
                csum_ctrl.hi = (cnt_reg == SUM_END);
                if (cnt_reg == SUM_END)
                begin
                    state_next = ST_CHK;
                end
            end

            ST_CHK:
            begin
                ch_next  = 5'd0;
                stp_next = 2'd0;
                state_next = csum_zero ? ST_FETCH : ST_IDLE;
            end

            ST_FETCH:
            begin
                if (stp_reg != 2'd0)
                begin
                    if (is_ext)
                    begin
                        unique case (fetch_j)
                            2'd0:    val_next[3:0]  = rd_data_reg[7:4];
                            2'd1:    val_next[7:4]  = rd_data_reg[7:4];
                            default: val_next[11:8] = rd_data_reg[7:4];
                        endcase
                    end
                    else
                    begin
                        if (fetch_j == 2'd0)
                        begin
                            val_next[7:0] = rd_data_reg;
                        end
                        else
                        begin
                            val_next[11:8] = rd_data_reg[3:0];
                        end
                    end
                end
                if (stp_reg == fetch_n)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    stp_next = stp_reg + 2'd1;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    out_idx_next  = ch_reg;
                    out_val_next  = val_reg;
                    out_last_next = (ch_reg == last_ch);
                    ch_next       = ch_reg + 5'd1;
                    stp_next      = 2'd0;
                    state_next    = (ch_reg == last_ch) ? ST_IDLE : ST_FETCH;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= 5'd0;
            cnt_reg      <= 6'd0;
            ch_reg       <= 5'd0;
            stp_reg      <= 2'd0;
            val_reg      <= 12'd0;
            ext_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            out_idx_reg  <= 5'd0;
            out_val_reg  <= 12'd0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            ch_reg       <= ch_next;
            stp_reg      <= stp_next;
            val_reg      <= val_next;
            ext_reg      <= ext_next;
            m_tvalid_reg <= m_tvalid_next;
            out_idx_reg  <= out_idx_next;
            out_val_reg  <= out_val_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_val_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

    // channel numbers never exceed the last extended channel
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_idx_reg <= LAST_EXT)
        else $error("channel index out of range");

    // a frame ends only on the last base or last extended channel
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (out_idx_reg == LAST_BASE || out_idx_reg == LAST_EXT))
        else $error("last flag on a middle channel");

    // the checksum verdict follows a complete sweep
    a_chk_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHK |-> $past(state_reg) == ST_SUM && $past(cnt_reg) == SUM_END)
        else $error("checksum checked before sweep ended");

    // a good command byte always advances to the payload
    a_hdr_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && dec_en_reg && pos_reg == 5'd1 && s_tdata == ibusfd_pkg::HDR_CMD_BYTE)
        |=> pos_reg == 5'd2)
        else $error("header did not advance position");

endmodule
